// File: hw/rtl/sac_pkg.sv
// Package for the sprite affine matrix block: transaction payload types,
// default parameters and the CORDIC arctangent table. No dependencies.
`default_nettype none

package sac_pkg;

  localparam int FRAC_BITS_DEF     = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_LEN          = 24;

  localparam int X_W = 33;
  localparam int Z_W = 49;

  localparam logic signed [X_W-1:0] GAIN_Q30 = 33'sd652032874;
  localparam logic [39:0]           DEG_UNIT = 40'd1000000000000;

  typedef struct packed {
    logic signed [31:0] size_x;
    logic signed [31:0] size_y;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pivot_x;
    logic signed [31:0] pivot_y;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] angle_deg;
  } quad_t;

  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic               saturated;
  } matrix_t;

  // Arctangent of 2^-i in units of 1e-12 degree.
  function automatic logic signed [Z_W-1:0] atan_deg(input int i);
    logic signed [Z_W-1:0] a;
    case (i)
      0:       a = 49'sd45000000000000;
      1:       a = 49'sd26565051177078;
      2:       a = 49'sd14036243467926;
      3:       a = 49'sd7125016348902;
      4:       a = 49'sd3576334374997;
      5:       a = 49'sd1789910608246;
      6:       a = 49'sd895173710211;
      7:       a = 49'sd447614170861;
      8:       a = 49'sd223810500369;
      9:       a = 49'sd111905677066;
      10:      a = 49'sd55952891894;
      11:      a = 49'sd27976452617;
      12:      a = 49'sd13988227142;
      13:      a = 49'sd6994113675;
      14:      a = 49'sd3497056851;
      15:      a = 49'sd1748528427;
      16:      a = 49'sd874264214;
      17:      a = 49'sd437132107;
      18:      a = 49'sd218566053;
      19:      a = 49'sd109283027;
      20:      a = 49'sd54641513;
      21:      a = 49'sd27320757;
      22:      a = 49'sd13660378;
      23:      a = 49'sd6830189;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sac_cordic.sv
// Pipelined rotation-mode CORDIC, one micro-rotation per register stage.
// Depends on sac_pkg for widths, the start gain and the arctangent table.
`default_nettype none

module sac_cordic import sac_pkg::*; #(
  parameter int STAGES = CORDIC_STAGES_DEF,
  parameter int SIDE_W = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire logic                     in_valid,
  input  wire logic signed [Z_W-1:0]    z_in,
  input  wire logic [SIDE_W-1:0]        side_in,
  output logic                          out_valid,
  output logic signed [X_W-1:0]         x_out,
  output logic signed [X_W-1:0]         y_out,
  output logic [SIDE_W-1:0]             side_out
);

  logic                  vr [STAGES];
  logic signed [X_W-1:0] xr [STAGES];
  logic signed [X_W-1:0] yr [STAGES];
  logic signed [Z_W-1:0] zr [STAGES];
  logic [SIDE_W-1:0]     sr [STAGES];

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic                  vi;
    logic signed [X_W-1:0] xi, yi, xs, ys;
    logic signed [Z_W-1:0] zi;
    logic [SIDE_W-1:0]     si;

    if (g == 0) begin : g_first
      assign vi = in_valid;
      assign xi = GAIN_Q30;
      assign yi = '0;
      assign zi = z_in;
      assign si = side_in;
    end else begin : g_next
      assign vi = vr[g-1];
      assign xi = xr[g-1];
      assign yi = yr[g-1];
      assign zi = zr[g-1];
      assign si = sr[g-1];
    end

    assign xs = xi >>> g;
    assign ys = yi >>> g;

    always_ff @(posedge clk) begin
      if (rst) begin
        vr[g] <= 1'b0;
      end else if (en) begin
        vr[g] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sr[g] <= si;
        if (!zi[Z_W-1]) begin
          xr[g] <= xi - ys;
          yr[g] <= yi + xs;
          zr[g] <= zi - atan_deg(g);
        end else begin
          xr[g] <= xi + ys;
          yr[g] <= yi - xs;
          zr[g] <= zi + atan_deg(g);
        end
      end
    end
  end

  assign out_valid = vr[STAGES-1];
  assign x_out     = xr[STAGES-1];
  assign y_out     = yr[STAGES-1];
  assign side_out  = sr[STAGES-1];

endmodule

`default_nettype wire

// File: hw/rtl/sprite_affine_matrix.sv
// Top level of the sprite affine matrix block: angle reduction, scaling,
// CORDIC sin/cos, matrix products and clamping. Depends on sac_pkg, sac_cordic.
//
//   channel   signals                            payload
//   quad      quad_valid, quad_ready, quad       quad_t, one sprite
//   matrix    matrix_valid, matrix_ready, matrix matrix_t, one matrix
//
// One transaction enters per cycle while matrix is not stalled; the CORDIC pipeline
// has min(CORDIC_STAGES, 24) stages, one rotation per stage.
// Reset clears the stage valid bits only. A stall on matrix freezes the whole
// pipeline, so quad_ready drops only while a finished matrix waits.
`default_nettype none

module sprite_affine_matrix import sac_pkg::*; #(
  parameter int FRAC_BITS     = FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    quad_valid,
  output logic         quad_ready,
  input  wire quad_t   quad,
  output logic         matrix_valid,
  input  wire logic    matrix_ready,
  output matrix_t      matrix
);

  localparam int F      = FRAC_BITS;
  localparam int CS     = CORDIC_STAGES < ATAN_LEN ? CORDIC_STAGES : ATAN_LEN;
  localparam int IW     = 32 - F;
  localparam int AW     = IW + 1 > 10 ? IW + 1 : 10;
  localparam int KSH    = AW + 9;
  localparam int RCP_W  = AW + 1;
  localparam int Q_W    = AW - 8;
  localparam int RV_W   = F + 10;
  localparam int PW     = 65 - F;
  localparam int CW     = F + 3;
  localparam int PROD_W = CW + PW;
  localparam int TW     = PROD_W - F;
  localparam int EW     = TW + 3;
  localparam int SB_W   = 4 + 64 + 4 * PW;
  localparam int SIDE_W = SB_W + 1;

  localparam logic [AW-1:0]    ANG_OFF = AW'(((2 ** (IW - 1)) + 359) / 360 * 360);
  localparam logic [RCP_W-1:0] RECIP   = RCP_W'((64'd1 << KSH) / 64'd360);
  localparam logic signed [RV_W-1:0] D90  = RV_W'(64'd90 << F);
  localparam logic signed [RV_W-1:0] D180 = RV_W'(64'd180 << F);
  localparam logic signed [RV_W-1:0] D270 = RV_W'(64'd270 << F);
  localparam logic signed [RV_W-1:0] D360 = RV_W'(64'd360 << F);

  logic adv;
  assign adv        = !matrix_valid || matrix_ready;
  assign quad_ready = adv;

  // Stage 1: scale magnitudes, raw products and the angle reciprocal product.
  logic [31:0]       ax, ay;
  logic [AW-1:0]     ang_off;
  logic              v1;
  logic [AW-1:0]     p1_ang;
  logic [AW+RCP_W-1:0] p1_qprod;
  logic [F-1:0]      p1_frac;
  logic signed [64:0] p1_szx, p1_szy, p1_psx, p1_psy;
  logic [3:0]        p1_sg;
  logic signed [31:0] p1_posx, p1_posy;

  assign ax      = quad.scale_x[31] ? (~quad.scale_x + 32'd1) : quad.scale_x;
  assign ay      = quad.scale_y[31] ? (~quad.scale_y + 32'd1) : quad.scale_y;
  assign ang_off = AW'($signed(quad.angle_deg[31:F])) + ANG_OFF;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= quad_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_ang   <= ang_off;
      p1_qprod <= (AW+RCP_W)'(ang_off) * (AW+RCP_W)'(RECIP);
      p1_frac  <= quad.angle_deg[F-1:0];
      p1_szx   <= 65'(quad.size_x) * $signed(65'(ax));
      p1_szy   <= 65'(quad.size_y) * $signed(65'(ay));
      p1_psx   <= 65'(quad.pivot_x) * $signed(65'(ax));
      p1_psy   <= 65'(quad.pivot_y) * $signed(65'(ay));
      p1_sg    <= {quad.scale_x[31], quad.scale_x == 32'd0,
                   quad.scale_y[31], quad.scale_y == 32'd0};
      p1_posx  <= quad.pos_x;
      p1_posy  <= quad.pos_y;
    end
  end

  // Stage 2: integer degrees modulo 360 and rounding of the scaled terms.
  logic [Q_W-1:0]    q;
  logic [AW-1:0]     rem_full;
  logic [9:0]        rem10;
  logic signed [64:0] rnd_szx, rnd_szy, rnd_psx, rnd_psy;
  logic              v2;
  logic [8:0]        p2_rem;
  logic [F-1:0]      p2_frac;
  logic [SB_W-1:0]   p2_side;

  assign q        = p1_qprod[AW+RCP_W-1:KSH];
  assign rem_full = p1_ang - AW'(q) * AW'(360);
  assign rem10    = rem_full[9:0];
  assign rnd_szx  = p1_szx + (65'sd1 <<< (F - 1));
  assign rnd_szy  = p1_szy + (65'sd1 <<< (F - 1));
  assign rnd_psx  = p1_psx + (65'sd1 <<< (F - 1));
  assign rnd_psy  = p1_psy + (65'sd1 <<< (F - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_rem  <= rem10 >= 10'd360 ? 9'(rem10 - 10'd360) : rem10[8:0];
      p2_frac <= p1_frac;
      p2_side <= {p1_sg, p1_posx, p1_posy, rnd_szx[64:F], rnd_szy[64:F],
                  rnd_psx[64:F], rnd_psy[64:F]};
    end
  end

  // Stage 3: fold into [-90, 90] and convert to 1e-12 degree units.
  logic signed [RV_W-1:0] rs, rf;
  logic                   fold_neg;
  logic [RV_W-1:0]        u;
  logic                   v3;
  logic [46:0]            p3_ia;
  logic [F+39:0]          p3_fb;
  logic                   p3_zneg;
  logic                   p3_neg;
  logic [SB_W-1:0]        p3_side;

  assign rs = $signed({1'b0, p2_rem, p2_frac});

  always_comb begin
    fold_neg = 1'b0;
    rf       = rs;
    if (rs > D90 && rs < D270) begin
      rf       = rs - D180;
      fold_neg = 1'b1;
    end else if (rs >= D270) begin
      rf = rs - D360;
    end
  end

  assign u = rf[RV_W-1] ? RV_W'(-rf) : RV_W'(rf);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_ia   <= 47'(u[F+6:F]) * 47'(DEG_UNIT);
      p3_fb   <= (F+40)'(u[F-1:0]) * (F+40)'(DEG_UNIT);
      p3_zneg <= rf[RV_W-1];
      p3_neg  <= fold_neg;
      p3_side <= p2_side;
    end
  end

  // Stage 4: residual angle for the CORDIC.
  logic [47:0]           units;
  logic                  v4;
  logic signed [Z_W-1:0] p4_z;
  logic [SIDE_W-1:0]     p4_side;

  assign units = 48'(p3_ia) + 48'(p3_fb >> F);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p4_z    <= p3_zneg ? -$signed(Z_W'(units)) : $signed(Z_W'(units));
      p4_side <= {p3_neg, p3_side};
    end
  end

  logic                  vc;
  logic signed [X_W-1:0] cx, cy;
  logic [SIDE_W-1:0]     cside;

  sac_cordic #(
    .STAGES (CS),
    .SIDE_W (SIDE_W)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v4),
    .z_in      (p4_z),
    .side_in   (p4_side),
    .out_valid (vc),
    .x_out     (cx),
    .y_out     (cy),
    .side_out  (cside)
  );

  // Stage 5: round cos and sin to FRAC_BITS and undo the fold.
  logic signed [X_W-1:0] rcx, rcy;
  logic signed [CW-1:0]  cc, cs_v;
  logic                  v5;
  logic signed [CW-1:0]  p5_c, p5_s;
  logic [SB_W-1:0]       p5_side;

  assign rcx  = cx + (X_W'(1) <<< (29 - F));
  assign rcy  = cy + (X_W'(1) <<< (29 - F));
  assign cc   = rcx[X_W-1:30-F];
  assign cs_v = rcy[X_W-1:30-F];

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p5_c    <= cside[SB_W] ? -cc : cc;
      p5_s    <= cside[SB_W] ? -cs_v : cs_v;
      p5_side <= cside[SB_W-1:0];
    end
  end

  logic [3:0]            sg5;
  logic signed [31:0]    posx5, posy5;
  logic signed [PW-1:0]  szx5, szy5, psx5, psy5;

  assign {sg5, posx5, posy5, szx5, szy5, psx5, psy5} = p5_side;

  // Stage 6: the eight rotation products.
  logic                     v6;
  logic signed [PROD_W-1:0] p6_prod [8];
  logic [3:0]               p6_sg;
  logic signed [31:0]       p6_posx, p6_posy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p6_prod[0] <= PROD_W'(p5_c) * PROD_W'(szx5);
      p6_prod[1] <= PROD_W'(p5_s) * PROD_W'(szy5);
      p6_prod[2] <= PROD_W'(p5_s) * PROD_W'(szx5);
      p6_prod[3] <= PROD_W'(p5_c) * PROD_W'(szy5);
      p6_prod[4] <= PROD_W'(p5_c) * PROD_W'(psx5);
      p6_prod[5] <= PROD_W'(p5_s) * PROD_W'(psy5);
      p6_prod[6] <= PROD_W'(p5_s) * PROD_W'(psx5);
      p6_prod[7] <= PROD_W'(p5_c) * PROD_W'(psy5);
      p6_sg      <= sg5;
      p6_posx    <= posx5;
      p6_posy    <= posy5;
    end
  end

  // Stage 7: round each product.
  logic                 v7;
  logic signed [TW-1:0] p7_t [8];
  logic [3:0]           p7_sg;
  logic signed [31:0]   p7_posx, p7_posy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (adv) begin
      v7 <= v6;
    end
  end

  for (genvar k = 0; k < 8; k++) begin : g_round
    logic signed [PROD_W-1:0] r;
    assign r = p6_prod[k] + (PROD_W'(1) <<< (F - 1));
    always_ff @(posedge clk) begin
      if (adv) begin
        p7_t[k] <= r[PROD_W-1:F];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p7_sg   <= p6_sg;
      p7_posx <= p6_posx;
      p7_posy <= p6_posy;
    end
  end

  // Stage 8: apply the axis signs and form the translation.
  function automatic logic signed [EW-1:0] apply_sign(input logic neg, input logic zero,
                                                      input logic signed [EW-1:0] v);
    logic signed [EW-1:0] r;
    if (zero) begin
      r = '0;
    end else if (neg) begin
      r = -v;
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic                 gxn, gxz, gyn, gyz;
  logic signed [EW-1:0] dx, dy;
  logic                 v8;
  logic signed [EW-1:0] p8_e [6];

  assign {gxn, gxz, gyn, gyz} = p7_sg;
  assign dx = EW'(p7_t[4]) - EW'(p7_t[5]);
  assign dy = EW'(p7_t[6]) + EW'(p7_t[7]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (adv) begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p8_e[0] <= apply_sign(gxn, gxz, EW'(p7_t[0]));
      p8_e[1] <= apply_sign(!gxn, gxz, EW'(p7_t[1]));
      p8_e[2] <= apply_sign(gyn, gyz, EW'(p7_t[2]));
      p8_e[3] <= apply_sign(gyn, gyz, EW'(p7_t[3]));
      p8_e[4] <= EW'(p7_posx) - apply_sign(gxn, gxz, dx);
      p8_e[5] <= EW'(p7_posy) - apply_sign(gyn, gyz, dy);
    end
  end

  // Stage 9: clamp to 32 bits; this is the output register.
  logic [31:0] cl [6];
  logic [5:0]  ovf;

  for (genvar k = 0; k < 6; k++) begin : g_clamp
    assign ovf[k] = !((&p8_e[k][EW-1:31]) || !(|p8_e[k][EW-1:31]));
    assign cl[k]  = ovf[k] ? (p8_e[k][EW-1] ? 32'h8000_0000 : 32'h7fff_ffff)
                           : p8_e[k][31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_valid <= 1'b0;
    end else if (adv) begin
      matrix_valid <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      matrix.m00       <= cl[0];
      matrix.m01       <= cl[1];
      matrix.m10       <= cl[2];
      matrix.m11       <= cl[3];
      matrix.trans_x   <= cl[4];
      matrix.trans_y   <= cl[5];
      matrix.saturated <= |ovf;
    end
  end

endmodule

`default_nettype wire
